@@ rtl/rsm_pkg.sv @@
package rsm_pkg;

  localparam int unsigned OUT_W  = 11;
  localparam int unsigned PW_W   = 16;
  localparam int unsigned PCT_W  = 8;
  localparam int unsigned STEP_W = 7;

  localparam logic [OUT_W-1:0]        NEUTRAL_US = 11'd1500;
  localparam logic [OUT_W-1:0]        OUT_MAX    = 11'd2047;
  localparam logic signed [PCT_W-1:0] PCT_LIMIT  = 8'sd100;

  // Event kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_CMD   = 2'd0,
    ACT_THR   = 2'd1,
    ACT_STEER = 2'd2
  } act_t;

  // Serial command characters
  localparam logic [7:0] CMD_AUTO   = 8'h61;  // 'a'
  localparam logic [7:0] CMD_BACK   = 8'h62;  // 'b'
  localparam logic [7:0] CMD_FWD    = 8'h66;  // 'f'
  localparam logic [7:0] CMD_LEFT   = 8'h6C;  // 'l'
  localparam logic [7:0] CMD_MANUAL = 8'h6D;  // 'm'
  localparam logic [7:0] CMD_THR0   = 8'h6E;  // 'n'
  localparam logic [7:0] CMD_RIGHT  = 8'h72;  // 'r'
  localparam logic [7:0] CMD_STEER0 = 8'h73;  // 's'

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ESTOP = 2'd0;
  localparam logic [1:0] REG_PMIN  = 2'd1;
  localparam logic [1:0] REG_PMAX  = 2'd2;
  localparam logic [1:0] REG_STEP  = 2'd3;

  typedef struct packed {
    logic              in_range;
    logic [PW_W-1:0]   width;
    logic [OUT_W-1:0]  width_sat;
  } meas_t;

  function automatic logic signed [PCT_W-1:0] step_pct(
    input logic signed [PCT_W-1:0] p,
    input logic signed [PCT_W-1:0] d
  );
    logic signed [PCT_W:0] v;
    v = {p[PCT_W-1], p} + {d[PCT_W-1], d};
    if (v > 9'sd100) begin
      return PCT_LIMIT;
    end else if (v < -9'sd100) begin
      return -PCT_LIMIT;
    end
    return v[PCT_W-1:0];
  endfunction

  // p * 450 / 100 truncated toward zero equals p * 9 / 2 truncated toward zero
  function automatic logic [OUT_W-1:0] steer_us(input logic signed [PCT_W-1:0] p);
    logic signed [11:0] p9;
    logic signed [11:0] half;
    logic signed [11:0] sum;
    p9   = $signed({{4{p[PCT_W-1]}}, p}) * 12'sd9;
    half = (p9 + $signed({11'd0, p9[11]})) >>> 1;
    sum  = half + 12'sd1500;
    return sum[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] thr_us(input logic signed [PCT_W-1:0] p);
    logic signed [11:0] sum;
    sum = $signed({{4{p[PCT_W-1]}}, p}) * 12'sd5 + 12'sd1500;
    return sum[OUT_W-1:0];
  endfunction

endpackage

@@ rtl/rsm_pulse_meas.sv @@
module rsm_pulse_meas
  import rsm_pkg::*;
(
  input  logic [PW_W-1:0] rise,
  input  logic [PW_W-1:0] now,
  input  logic [PW_W-1:0] pulse_min,
  input  logic [PW_W-1:0] pulse_max,
  output meas_t           meas
);

  logic [PW_W-1:0] width;

  // width modulo 65536 only needs the low timestamp bits
  assign width = now - rise;

  always_comb begin
    meas.width     = width;
    meas.in_range  = (width >= pulse_min) && (width <= pulse_max);
    meas.width_sat = (width > PW_W'(OUT_MAX)) ? OUT_MAX : width[OUT_W-1:0];
  end

endmodule

@@ rtl/rc_servo_mux_with_estop_core.sv @@
// Throttle and steering servo multiplexer with remote e-stop. Each request is
// one event: a serial command byte (tuser 0), a throttle pin edge (tuser 1) or
// a steering pin edge (tuser 2); every request yields exactly one result with
// the current servo pulse widths, the mode and the movement-enable flag. One
// request is taken per clock while the result is not stalled: a request lands
// in an input register, and once the result register is free the state update
// loads the result register from it, so each result is offered from the result
// register. While the result is stalled one more request can wait in the input
// register before tready drops. After reset the block is in auto mode with both
// outputs at 1500 us and movement off.
module rc_servo_mux_with_estop_core
  import rsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] command_byte, [8] pin_level, [40:9] time_us, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] throttle_pulse_us, [21:11] steering_pulse_us, [22] auto_active,
  // [23] movement_on
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [OUT_W-1:0]  estop_threshold;
  logic [PW_W-1:0]   pulse_min;
  logic [PW_W-1:0]   pulse_max;
  logic [STEP_W-1:0] percent_step;

  // input register
  logic            in_valid;
  logic [1:0]      in_act;
  logic [7:0]      in_byte;
  logic            in_level;
  logic [PW_W-1:0] in_time;

  // block state
  logic                    auto_mode, auto_mode_next;
  logic                    movement, movement_next;
  logic signed [PCT_W-1:0] thr_pct, thr_pct_next;
  logic signed [PCT_W-1:0] steer_pct, steer_pct_next;
  logic [PW_W-1:0]         thr_rise, thr_rise_next;
  logic [PW_W-1:0]         steer_rise, steer_rise_next;
  logic [OUT_W-1:0]        thr_out, thr_out_next;
  logic [OUT_W-1:0]        steer_out, steer_out_next;

  logic                    out_free;
  logic                    advance;
  logic signed [PCT_W-1:0] step_s;
  meas_t                   thr_meas;
  meas_t                   steer_meas;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign step_s        = $signed({1'b0, percent_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      estop_threshold <= 11'd1700;
      pulse_min       <= 16'd1000;
      pulse_max       <= 16'd2000;
      percent_step    <= 7'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ESTOP: estop_threshold <= cfg_data[OUT_W-1:0];
        REG_PMIN:  pulse_min       <= cfg_data;
        REG_PMAX:  pulse_max       <= cfg_data;
        REG_STEP:  percent_step    <= cfg_data[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act   <= s_axis_tuser;
      in_byte  <= s_axis_tdata[7:0];
      in_level <= s_axis_tdata[8];
      in_time  <= s_axis_tdata[24:9];
    end
  end

  rsm_pulse_meas u_thr_meas (
    .rise      (thr_rise),
    .now       (in_time),
    .pulse_min (pulse_min),
    .pulse_max (pulse_max),
    .meas      (thr_meas)
  );

  rsm_pulse_meas u_steer_meas (
    .rise      (steer_rise),
    .now       (in_time),
    .pulse_min (pulse_min),
    .pulse_max (pulse_max),
    .meas      (steer_meas)
  );

  always_comb begin
    auto_mode_next  = auto_mode;
    movement_next   = movement;
    thr_pct_next    = thr_pct;
    steer_pct_next  = steer_pct;
    thr_rise_next   = thr_rise;
    steer_rise_next = steer_rise;
    thr_out_next    = thr_out;
    steer_out_next  = steer_out;

    case (in_act)
      ACT_CMD: begin
        if (!auto_mode) begin
          if (in_byte == CMD_AUTO) begin
            auto_mode_next  = 1'b1;
            thr_rise_next   = '0;
            steer_rise_next = '0;
            thr_out_next    = NEUTRAL_US;
            steer_out_next  = NEUTRAL_US;
          end
        end else begin
          unique case (in_byte) inside
            CMD_RIGHT, CMD_LEFT: begin
              steer_pct_next = step_pct(steer_pct,
                                        (in_byte == CMD_RIGHT) ? step_s : -step_s);
              if (movement) begin
                steer_out_next = steer_us(steer_pct_next);
              end
            end
            CMD_FWD, CMD_BACK: begin
              thr_pct_next = step_pct(thr_pct, (in_byte == CMD_FWD) ? step_s : -step_s);
              if (movement) begin
                thr_out_next = thr_us(thr_pct_next);
              end
            end
            CMD_STEER0: begin
              steer_pct_next = '0;
              if (movement) begin
                steer_out_next = NEUTRAL_US;
              end
            end
            CMD_THR0: begin
              thr_pct_next = '0;
              if (movement) begin
                thr_out_next = NEUTRAL_US;
              end
            end
            CMD_MANUAL: begin
              thr_pct_next   = '0;
              steer_pct_next = '0;
              auto_mode_next = 1'b0;
              thr_out_next   = NEUTRAL_US;
              steer_out_next = NEUTRAL_US;
            end
            default: ;
          endcase
        end
      end
      ACT_THR: begin
        if (in_level) begin
          thr_rise_next = in_time;
        end else if (thr_meas.in_range) begin
          if (auto_mode) begin
            movement_next = thr_meas.width > PW_W'(estop_threshold);
          end else begin
            thr_out_next = thr_meas.width_sat;
          end
        end
      end
      ACT_STEER: begin
        // steering edges count in manual mode only
        if (!auto_mode) begin
          if (in_level) begin
            steer_rise_next = in_time;
          end else if (steer_meas.in_range) begin
            steer_out_next = steer_meas.width_sat;
          end
        end
      end
      default: ;
    endcase

    // hold throttle at neutral while the e-stop is off in auto mode
    if (auto_mode_next && !movement_next) begin
      thr_out_next = NEUTRAL_US;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode  <= 1'b1;
      movement   <= 1'b0;
      thr_pct    <= '0;
      steer_pct  <= '0;
      thr_rise   <= '0;
      steer_rise <= '0;
      thr_out    <= NEUTRAL_US;
      steer_out  <= NEUTRAL_US;
    end else if (advance) begin
      auto_mode  <= auto_mode_next;
      movement   <= movement_next;
      thr_pct    <= thr_pct_next;
      steer_pct  <= steer_pct_next;
      thr_rise   <= thr_rise_next;
      steer_rise <= steer_rise_next;
      thr_out    <= thr_out_next;
      steer_out  <= steer_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {movement_next, auto_mode_next, steer_out_next, thr_out_next};
    end
  end

  a_estop_hold: assert property (@(posedge clk) disable iff (rst)
    (auto_mode && !movement) |-> (thr_out == NEUTRAL_US))
    else $error("throttle not held at neutral while e-stop is off");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    (thr_pct <= PCT_LIMIT) && (thr_pct >= -PCT_LIMIT) &&
    (steer_pct <= PCT_LIMIT) && (steer_pct >= -PCT_LIMIT))
    else $error("percent out of range");

  a_manual_centre: assert property (@(posedge clk) disable iff (rst)
    $fell(auto_mode) |-> (thr_out == NEUTRAL_US) && (steer_out == NEUTRAL_US) &&
                         (thr_pct == '0) && (steer_pct == '0))
    else $error("manual switch did not centre outputs");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("processed request produced no result");

endmodule
